// File: src/scpr_pkg.sv
package scpr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 4096;

  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned CRC_BYTES = 2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_BAD_ESC = 2'd3
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [11:0] byte_index;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    logic [15:0] decl_len;
    status_e     status;
  } res_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: src/scpr_deframer.sv
module scpr_deframer import scpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_i,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam int unsigned CAP   = MAX_PAYLOAD + HDR_BYTES + CRC_BYTES + 1;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned FRAME_OVH = HDR_BYTES + CRC_BYTES;

  logic             esc_pend_q, esc_pend_d;
  logic             esc_err_q, esc_err_d;
  logic             seen_q, seen_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       hold_q [2];
  logic [7:0]       hold_d [2];
  logic [7:0]       type_q, type_d;
  logic [7:0]       seq_q, seq_d;
  logic [15:0]      len_q, len_d;

  always_comb begin
    logic        take;
    logic [7:0]  d;
    logic [31:0] idx;
    logic [15:0] recv;
    esc_pend_d  = esc_pend_q;
    esc_err_d   = esc_err_q;
    seen_d      = seen_q;
    count_d     = count_q;
    crc_d       = crc_q;
    hold_d      = hold_q;
    type_d      = type_q;
    seq_d       = seq_q;
    len_d       = len_q;
    take        = 1'b0;
    d           = rx_byte_i;
    idx         = 32'(count_q) - 32'(FRAME_OVH);
    recv        = {hold_q[0], hold_q[1]};
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DATA, data_byte: 8'h00, byte_index: 12'h000,
                    frame_type: type_q, frame_seq: seq_q, decl_len: len_q,
                    status: ST_OK};

    if (req_i) begin
      if (rx_byte_i == CODE_END) begin
        if (seen_q) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_STATUS;
          if (esc_err_q || esc_pend_q) begin
            res_o.status = ST_BAD_ESC;
          end else if (32'(count_q) < 32'(FRAME_OVH) || 32'(count_q) >= 32'(CAP) ||
                       32'(count_q) != 32'(len_q) + 32'(FRAME_OVH)) begin
            res_o.status = ST_BAD_LEN;
          end else if (recv != crc_q) begin
            res_o.status = ST_BAD_CRC;
          end
        end
        esc_pend_d = 1'b0;
        esc_err_d  = 1'b0;
        seen_d     = 1'b0;
        count_d    = '0;
        crc_d      = CRC_INIT;
        hold_d[0]  = 8'h00;
        hold_d[1]  = 8'h00;
        type_d     = 8'h00;
        seq_d      = 8'h00;
        len_d      = 16'h0000;
      end else begin
        seen_d = 1'b1;
        if (esc_pend_q) begin
          esc_pend_d = 1'b0;
          if (rx_byte_i == CODE_ESC_END) begin
            take = 1'b1;
            d    = CODE_END;
          end else if (rx_byte_i == CODE_ESC_ESC) begin
            take = 1'b1;
            d    = CODE_ESC;
          end else begin
            esc_err_d = 1'b1;
          end
        end else if (rx_byte_i == CODE_ESC) begin
          esc_pend_d = 1'b1;
        end else begin
          take = 1'b1;
        end
      end

      if (take && 32'(count_q) < 32'(CAP)) begin
        if (count_q == CNT_W'(0)) type_d = d;
        if (count_q == CNT_W'(1)) seq_d = d;
        if (count_q == CNT_W'(2)) len_d[7:0] = d;
        if (count_q == CNT_W'(3)) len_d[15:8] = d;
        if (32'(count_q) >= 32'(CRC_BYTES)) begin
          crc_d = crc_byte(crc_q, hold_q[1]);
          if (32'(count_q) >= 32'(FRAME_OVH) && !esc_err_q &&
              idx < 32'(len_q) && idx < 32'(MAX_PAYLOAD)) begin
            res_valid_o      = 1'b1;
            res_o.data_byte  = hold_q[1];
            res_o.byte_index = idx[11:0];
          end
        end
        hold_d[1] = hold_q[0];
        hold_d[0] = d;
        count_d   = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pend_q <= 1'b0;
      esc_err_q  <= 1'b0;
      seen_q     <= 1'b0;
      count_q    <= '0;
      crc_q      <= CRC_INIT;
      hold_q[0]  <= 8'h00;
      hold_q[1]  <= 8'h00;
      type_q     <= 8'h00;
      seq_q      <= 8'h00;
      len_q      <= 16'h0000;
    end else begin
      esc_pend_q <= esc_pend_d;
      esc_err_q  <= esc_err_d;
      seen_q     <= seen_d;
      count_q    <= count_d;
      crc_q      <= crc_d;
      hold_q     <= hold_d;
      type_q     <= type_d;
      seq_q      <= seq_d;
      len_q      <= len_d;
    end
  end

endmodule

// File: src/scpr_out_buf.sv
module scpr_out_buf import scpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

// File: src/slip_crc_packet_receiver.sv
// SLIP receiver with CRC-16/CCITT-FALSE check. Each accepted rx byte is decoded in
// the cycle it is taken; a byte that completes a payload position, or an END closing
// a non-empty frame, yields one request on the output channel. The block takes one
// byte per cycle while in_ready_o is high, with a combinational escape decode and
// an unrolled byte-wide CRC update; a two-entry output buffer absorbs one more
// result while the output stalls, after which in_ready_o drops until the consumer
// drains a result. Payload bytes beyond MAX_PAYLOAD are checked but not reported.
module slip_crc_packet_receiver import scpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [11:0] byte_index_o,
  output logic [7:0]  frame_type_o,
  output logic [7:0]  frame_seq_o,
  output logic [15:0] decl_len_o,
  output logic [1:0]  status_o
);

  logic req;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign req = in_valid_i && in_ready_o;

  scpr_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  scpr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_res)
  );

  assign kind_o       = out_res.kind;
  assign data_byte_o  = out_res.data_byte;
  assign byte_index_o = out_res.byte_index;
  assign frame_type_o = out_res.frame_type;
  assign frame_seq_o  = out_res.frame_seq;
  assign decl_len_o   = out_res.decl_len;
  assign status_o     = out_res.status;

endmodule

// File: src/scpr_checker.sv
module scpr_checker import scpr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        kind_o,
  input logic [7:0]  data_byte_o,
  input logic [11:0] byte_index_o,
  input logic [7:0]  frame_type_o,
  input logic [7:0]  frame_seq_o,
  input logic [15:0] decl_len_o,
  input logic [1:0]  status_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("input request changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(data_byte_o) && $stable(byte_index_o) && $stable(status_o) &&
      $stable(frame_type_o) && $stable(frame_seq_o) && $stable(decl_len_o))
    else $error("output request changed while stalled");

  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending output");

  a_stall_persists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("input ready rose without output drain");

  a_data_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DATA |->
      status_o == ST_OK && {4'h0, byte_index_o} < decl_len_o)
    else $error("payload byte outside declared length");

endmodule

bind slip_crc_packet_receiver scpr_checker u_scpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .rx_byte_i   (rx_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .data_byte_o (data_byte_o),
  .byte_index_o(byte_index_o),
  .frame_type_o(frame_type_o),
  .frame_seq_o (frame_seq_o),
  .decl_len_o  (decl_len_o),
  .status_o    (status_o)
);

// File: sim/tb_slip_crc_packet_receiver.sv
module tb_slip_crc_packet_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import scpr_pkg::*;

  localparam int unsigned MAX_PL    = MAX_PAYLOAD_DEF;
  localparam int unsigned COUNT_CAP = MAX_PL + 7;

  typedef enum int {
    FLAW_NONE,
    FLAW_CRC,
    FLAW_ESC,
    FLAW_ESC_AT_END,
    FLAW_CUT
  } flaw_e;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic [11:0] byte_index_o;
  logic [7:0]  frame_type_o;
  logic [7:0]  frame_seq_o;
  logic [15:0] decl_len_o;
  logic [1:0]  status_o;

  slip_crc_packet_receiver #(
    .MAX_PAYLOAD(MAX_PL)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .byte_index_o(byte_index_o),
    .frame_type_o(frame_type_o),
    .frame_seq_o (frame_seq_o),
    .decl_len_o  (decl_len_o),
    .status_o    (status_o)
  );

  logic [7:0] line_bytes_q[$];
  res_t       decoded_q[$];
  int         err_count = 0;

  // receiver state as tracked by the testbench
  bit          rx_esc     = 1'b0;
  bit          rx_esc_err = 1'b0;
  bit          rx_seen    = 1'b0;
  int unsigned rx_count   = 0;
  logic [15:0] rx_crc     = CRC_INIT;
  logic [7:0]  rx_hold[2] = '{8'h00, 8'h00};
  logic [7:0]  rx_type    = 8'h00;
  logic [7:0]  rx_seq     = 8'h00;
  logic [15:0] rx_len     = 16'h0000;

  int gap_left = 0, icalm_left = 0, stall_left = 0, ocalm_left = 0;
  bit icalm = 1'b0, ocalm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  function automatic res_t make_result(logic kind, logic [7:0] data, logic [11:0] idx,
                                       status_e st);
    res_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.byte_index = idx;
    r.frame_type = rx_type;
    r.frame_seq  = rx_seq;
    r.decl_len   = rx_len;
    r.status     = st;
    return r;
  endfunction

  task automatic absorb_decoded(logic [7:0] d);
    logic [7:0]  leaving;
    int unsigned idx;
    if (rx_count >= COUNT_CAP) return;
    case (rx_count)
      0: rx_type = d;
      1: rx_seq = d;
      2: rx_len[7:0] = d;
      3: rx_len[15:8] = d;
      default: ;
    endcase
    if (rx_count >= 2) begin
      leaving = rx_hold[1];
      rx_crc  = crc16_next(rx_crc, leaving);
      if (rx_count >= 6 && !rx_esc_err) begin
        idx = rx_count - 6;
        if (idx < rx_len && idx < MAX_PL)
          decoded_q.push_back(make_result(KIND_DATA, leaving, idx[11:0], ST_OK));
      end
    end
    rx_hold[1] = rx_hold[0];
    rx_hold[0] = d;
    rx_count++;
  endtask

  task automatic decode_line_byte(logic [7:0] b);
    status_e st;
    if (b == CODE_END) begin
      if (rx_seen) begin
        if (rx_esc_err || rx_esc)
          st = ST_BAD_ESC;
        else if (rx_count < 6 || rx_count >= COUNT_CAP || rx_count != rx_len + 6)
          st = ST_BAD_LEN;
        else if ({rx_hold[0], rx_hold[1]} != rx_crc)
          st = ST_BAD_CRC;
        else
          st = ST_OK;
        decoded_q.push_back(make_result(KIND_STATUS, 8'h00, 12'h000, st));
      end
      rx_esc     = 1'b0;
      rx_esc_err = 1'b0;
      rx_seen    = 1'b0;
      rx_count   = 0;
      rx_crc     = CRC_INIT;
      rx_hold    = '{8'h00, 8'h00};
      rx_type    = 8'h00;
      rx_seq     = 8'h00;
      rx_len     = 16'h0000;
    end else begin
      rx_seen = 1'b1;
      if (rx_esc) begin
        rx_esc = 1'b0;
        if (b == CODE_ESC_END) absorb_decoded(CODE_END);
        else if (b == CODE_ESC_ESC) absorb_decoded(CODE_ESC);
        else rx_esc_err = 1'b1;
      end else if (b == CODE_ESC) begin
        rx_esc = 1'b1;
      end else begin
        absorb_decoded(b);
      end
    end
  endtask

  function automatic int next_gap(inout int calm_left, inout bit calm);
    int r;
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(20, 300);
    end
    calm_left--;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 11))
      0: return CODE_END;
      1: return CODE_ESC;
      2: return CODE_ESC_END;
      3: return CODE_ESC_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // header, payload and CRC with an optional injected flaw, SLIP-encoded and closed by END
  task automatic put_frame(logic [7:0] ftype, logic [7:0] fseq, logic [15:0] flen,
                           logic [7:0] pay[$], flaw_e flaw);
    logic [7:0]  dec[$];
    logic [15:0] crc;
    logic [7:0]  junk;
    int          bad_at;
    dec.push_back(ftype);
    dec.push_back(fseq);
    dec.push_back(flen[7:0]);
    dec.push_back(flen[15:8]);
    foreach (pay[i]) dec.push_back(pay[i]);
    crc = CRC_INIT;
    foreach (dec[i]) crc = crc16_next(crc, dec[i]);
    if (flaw == FLAW_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    dec.push_back(crc[7:0]);
    dec.push_back(crc[15:8]);
    if (flaw == FLAW_CUT) repeat ($urandom_range(1, 3)) void'(dec.pop_back());
    bad_at = (flaw == FLAW_ESC) ? $urandom_range(0, dec.size() - 1) : -1;
    foreach (dec[i]) begin
      if (i == bad_at) begin
        do junk = 8'($urandom_range(0, 255));
        while (junk == CODE_END || junk == CODE_ESC_END || junk == CODE_ESC_ESC);
        line_bytes_q.push_back(CODE_ESC);
        line_bytes_q.push_back(junk);
      end
      if (dec[i] == CODE_END) begin
        line_bytes_q.push_back(CODE_ESC);
        line_bytes_q.push_back(CODE_ESC_END);
      end else if (dec[i] == CODE_ESC) begin
        line_bytes_q.push_back(CODE_ESC);
        line_bytes_q.push_back(CODE_ESC_ESC);
      end else begin
        line_bytes_q.push_back(dec[i]);
      end
    end
    if (flaw == FLAW_ESC_AT_END) line_bytes_q.push_back(CODE_ESC);
    line_bytes_q.push_back(CODE_END);
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    res_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("result with nothing outstanding");
      return;
    end
    want = decoded_q.pop_front();
    check_field("kind", kind_o, want.kind);
    check_field("data_byte", data_byte_o, want.data_byte);
    check_field("byte_index", byte_index_o, want.byte_index);
    check_field("frame_type", frame_type_o, want.frame_type);
    check_field("frame_seq", frame_seq_o, want.frame_seq);
    check_field("decl_len", decl_len_o, want.decl_len);
    check_field("status", status_o, want.status);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
    end else begin
      if (in_valid_i && in_ready_o) decode_line_byte(rx_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (line_bytes_q.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= line_bytes_q.pop_front();
          gap_left   = next_gap(icalm_left, icalm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_result();
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = next_gap(ocalm_left, ocalm);
      end
    end
  end

  initial begin
    int          r, n, base;
    logic [15:0] flen;
    logic [7:0]  pay[$];
    flaw_e       flaw;

    // empty frame, escaped payload, bad crc, bad escape, END after ESC, short frame
    line_bytes_q.push_back(CODE_END);
    pay.push_back(CODE_END);
    pay.push_back(CODE_ESC);
    put_frame(8'hFF, 8'h00, 16'd2, pay, FLAW_NONE);
    pay.delete();
    put_frame(8'h5A, 8'hA5, 16'd0, pay, FLAW_CRC);
    line_bytes_q.push_back(8'h41);
    line_bytes_q.push_back(CODE_ESC);
    line_bytes_q.push_back(8'h41);
    line_bytes_q.push_back(CODE_END);
    line_bytes_q.push_back(CODE_ESC);
    line_bytes_q.push_back(CODE_END);
    line_bytes_q.push_back(8'h12);
    line_bytes_q.push_back(CODE_END);

    // oversize frame: count saturates, indexes cover the full payload window
    repeat (MAX_PL + 4) pay.push_back(rand_data());
    put_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'hFFFF, pay,
              FLAW_NONE);

    base = line_bytes_q.size();
    while (line_bytes_q.size() < base + 1200) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6)) line_bytes_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 12) begin
        line_bytes_q.push_back(CODE_END);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        pay.delete();
        repeat (n) pay.push_back(rand_data());
        flen = 16'(n);
        r = $urandom_range(0, 99);
        if (r < 5) flen = 16'(n + $urandom_range(1, 3));
        else if (r < 10) flen = 16'($urandom_range(0, 65535));
        flaw = (r >= 10 && r < 18) ? FLAW_CRC :
               (r >= 18 && r < 24) ? FLAW_ESC :
               (r >= 24 && r < 28) ? FLAW_ESC_AT_END :
               (r >= 28 && r < 32) ? FLAW_CUT : FLAW_NONE;
        put_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), flen, pay,
                  flaw);
      end
    end
    line_bytes_q.push_back(CODE_END);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (line_bytes_q.size() != 0 || in_valid_i || decoded_q.size() != 0);
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb_slip_crc_packet_receiver: clean");
    end else begin
      $display("tb_slip_crc_packet_receiver: errors");
    end
    $finish;
  end

  initial begin
    #36_000_000;
    $display("tb_slip_crc_packet_receiver: errors");
    $finish;
  end

endmodule

// File: filelist.f
src/scpr_pkg.sv
src/scpr_deframer.sv
src/scpr_out_buf.sv
src/slip_crc_packet_receiver.sv
src/scpr_checker.sv
sim/tb_slip_crc_packet_receiver.sv
